FILE: src/lxac_pkg.sv
// ----------------------------------------------------------------------------
// lxac_pkg
// Shared types, constants and helpers for the lane xor/add checksum block.
// ----------------------------------------------------------------------------
package lxac_pkg;

    localparam int unsigned LANE_COUNT  = 16;
    localparam int unsigned LANE_IDX_W  = 4;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROT_W       = 5;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [WORD_W-1:0] MIX_SEED = 32'h9E3779B9;

    typedef logic [WORD_W-1:0] t_word;

    // one closed message handed from front to back
    typedef struct packed {
        t_word [LANE_COUNT-1:0] lanes;
        t_word                  count;
    } t_snap;

    // back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_MIX
    } t_back_state;

    // per-lane key table (pi digits)
    function automatic t_word lane_key(input logic [LANE_IDX_W-1:0] idx);
        t_word k;
        case (idx)
            4'd0:    k = 32'h243F6A88;
            4'd1:    k = 32'h85A308D3;
            4'd2:    k = 32'h13198A2E;
            4'd3:    k = 32'h03707344;
            4'd4:    k = 32'hA4093822;
            4'd5:    k = 32'h299F31D0;
            4'd6:    k = 32'h082EFA98;
            4'd7:    k = 32'hEC4E6C89;
            4'd8:    k = 32'h452821E6;
            4'd9:    k = 32'h38D01377;
            4'd10:   k = 32'hBE5466CF;
            4'd11:   k = 32'h34E90C6C;
            4'd12:   k = 32'hC0AC29B7;
            4'd13:   k = 32'hC97C50DD;
            4'd14:   k = 32'h3F84D5B5;
            4'd15:   k = 32'hB5470917;
            default: k = '0;
        endcase
        return k;
    endfunction

    // rotate left by r (shift by full width yields zero, so r = 0 works)
    function automatic t_word rotl(input t_word x, input logic [ROT_W-1:0] r);
        logic [ROT_W:0] rr;
        rr = 6'd32 - {1'b0, r};
        return (x << r) | (x >> rr);
    endfunction

endpackage

FILE: src/lxac_front.sv
// ----------------------------------------------------------------------------
// lxac_front
// Accepts message words, folds them into the lanes and counts them; on a
// closing request it hands the finished lanes and count to the queue.
// ----------------------------------------------------------------------------
module lxac_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lxac_pkg::t_word   i_word,
    input  logic              i_carries_word,
    input  logic              i_last,
    output logic              o_q_push,
    output lxac_pkg::t_snap   o_q_data
);

    lxac_pkg::t_word [lxac_pkg::LANE_COUNT-1:0] r_lanes;
    lxac_pkg::t_word [lxac_pkg::LANE_COUNT-1:0] n_lanes;
    lxac_pkg::t_word                            r_count;
    lxac_pkg::t_word                            n_count;
    logic [lxac_pkg::LANE_IDX_W-1:0]            lane_idx;
    lxac_pkg::t_word                            keyed_word;

    // fold the word into lane (count mod 16)
    always_comb begin
        lane_idx   = r_count[lxac_pkg::LANE_IDX_W-1:0];
        keyed_word = i_word + lxac_pkg::lane_key(lane_idx);
        n_lanes    = r_lanes;
        n_count    = r_count;
        if (i_accept && i_carries_word) begin
            n_lanes[lane_idx] = r_lanes[lane_idx] ^ keyed_word;
            n_count           = r_count + 32'd1;
        end
    end

    // closing request ships the updated state to the back end
    assign o_q_push       = i_accept && i_last;
    assign o_q_data.lanes = n_lanes;
    assign o_q_data.count = n_count;

    // lane and count registers, cleared when a message closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= '0;
            r_count <= '0;
        end else if (o_q_push) begin
            r_lanes <= '0;
            r_count <= '0;
        end else begin
            r_lanes <= n_lanes;
            r_count <= n_count;
        end
    end

endmodule

FILE: src/lxac_queue.sv
// ----------------------------------------------------------------------------
// lxac_queue
// Short queue of closed messages between the front and the back end.
// ----------------------------------------------------------------------------
module lxac_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lxac_pkg::t_snap   i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output lxac_pkg::t_snap   o_head
);

    lxac_pkg::t_snap                r_mem [lxac_pkg::QUEUE_DEPTH];
    logic [lxac_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [lxac_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [lxac_pkg::QCNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == lxac_pkg::QCNT_W'(lxac_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/lxac_back.sv
// ----------------------------------------------------------------------------
// lxac_back
// Runs the sixteen-step rotate/xor mix over one closed message, one lane per
// cycle (the last lane stalls until the output is free), and holds the checksum in an output register until taken.
// ----------------------------------------------------------------------------
module lxac_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  lxac_pkg::t_snap   i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output lxac_pkg::t_word   o_checksum
);

    lxac_pkg::t_back_state           r_state;
    lxac_pkg::t_back_state           n_state;
    logic [lxac_pkg::LANE_IDX_W-1:0] r_step;
    logic [lxac_pkg::LANE_IDX_W-1:0] n_step;
    lxac_pkg::t_word                 r_acc;
    lxac_pkg::t_word                 n_acc;
    logic                            r_out_valid;
    logic                            n_out_valid;
    lxac_pkg::t_word                 r_out_data;
    lxac_pkg::t_word                 n_out_data;
    lxac_pkg::t_word                 mixed;
    logic                            last_step;
    logic                            out_free;

    // one mix step on the current lane
    always_comb begin
        mixed     = lxac_pkg::rotl(r_acc ^ i_q_head.lanes[r_step],
                                   {1'b0, r_step} + lxac_pkg::ROT_W'(1));
        last_step = (r_step == lxac_pkg::LANE_IDX_W'(lxac_pkg::LANE_COUNT - 1));
        out_free  = !r_out_valid || i_pop;
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_pop;
        n_out_data  = r_out_data;
        o_q_pop     = 1'b0;
        case (r_state)
            lxac_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = lxac_pkg::BK_MIX;
                    n_step  = '0;
                    n_acc   = lxac_pkg::MIX_SEED;
                end
            end
            lxac_pkg::BK_MIX: begin
                if (!last_step) begin
                    n_acc  = mixed;
                    n_step = r_step + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mixed ^ i_q_head.count;
                    o_q_pop     = 1'b1;
                    n_state     = lxac_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lxac_pkg::BK_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lxac_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_empty    = !r_out_valid;
    assign o_checksum = r_out_data;

endmodule

FILE: src/lane_xor_add_checksum.sv
// ----------------------------------------------------------------------------
// lane_xor_add_checksum
// Sixteen-lane xor/add checksum over a stream of 32-bit message words.
// ----------------------------------------------------------------------------
// The front end takes one word per cycle whenever full is low: each word is
// keyed and xored into lane (count mod 16), and a request with last set closes
// the message and moves its lanes and count into a two-entry message queue.
// The back end mixes a queued message one lane per clock, the last lane waiting
// while the previous checksum has not been popped: a load step puts the seed
// into the accumulator, then 16 mix steps fold in the lanes, and the count is
// xored in as the result is written to the output register. The front end keeps
// taking one word per cycle while full is low, also while the back end mixes;
// full rises only while two closed messages wait in the queue.
module lane_xor_add_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_word,
    input  logic        i_carries_word,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_checksum
);

    logic            accept;
    logic            q_push;
    lxac_pkg::t_snap q_wr_data;
    logic            q_pop;
    logic            q_empty;
    lxac_pkg::t_snap q_head;

    // input request accepted
    assign accept = push && !full;

    // word folding front end
    lxac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_word         (i_word),
        .i_carries_word (i_carries_word),
        .i_last         (i_last),
        .o_q_push       (q_push),
        .o_q_data       (q_wr_data)
    );

    // closed message queue
    lxac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // final mix and result register
    lxac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_checksum (o_checksum)
    );

endmodule
